// ===== sv/vigenere_key_recovery_defines.svh =====
// Assertion macros shared by the key recovery RTL.
`ifndef VIGENERE_KEY_RECOVERY_DEFINES_SVH
`define VIGENERE_KEY_RECOVERY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define VKR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define VKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vkr_pkg.sv =====
// Shared constants, types and the letter weight table for key recovery.
package vkr_pkg;

  localparam int unsigned MAX_KEY_DEF    = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned ALPHABET       = 26;

  // Fixed point scoring: weights are English frequencies times 65536
  localparam int unsigned WEIGHT_W     = 14;
  localparam int unsigned TARGET_SCORE = 4292;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned STEP_W       = 5;

  // ASCII codes
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7a;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_Z = 8'h5a;
  localparam logic [6:0] KEY_BASE = 7'h61;

  // Register map (index is paddr[2])
  localparam logic       REG_KEY_LENGTH   = 1'b0;
  localparam logic [5:0] KEY_LENGTH_RESET = 6'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_SCORE,
    ST_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    EN_IDLE,
    EN_LOAD,
    EN_TARGET,
    EN_SHIFT,
    EN_DONE
  } eng_state_e;

  // Control from sequencer to scoring engine
  typedef struct packed {
    logic start;
    logic take;
  } eng_ctrl_t;

  // Result from scoring engine
  typedef struct packed {
    logic               valid;
    logic [SHIFT_W-1:0] shift;
  } res_t;

  function automatic logic [WEIGHT_W-1:0] eng_weight(input logic [STEP_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    unique case (idx)
      5'd0:    w = 14'd5352;
      5'd1:    w = 14'd978;
      5'd2:    w = 14'd1823;
      5'd3:    w = 14'd2787;
      5'd4:    w = 14'd8324;
      5'd5:    w = 14'd1460;
      5'd6:    w = 14'd1321;
      5'd7:    w = 14'd3994;
      5'd8:    w = 14'd4565;
      5'd9:    w = 14'd100;
      5'd10:   w = 14'd506;
      5'd11:   w = 14'd2638;
      5'd12:   w = 14'd1577;
      5'd13:   w = 14'd4423;
      5'd14:   w = 14'd4920;
      5'd15:   w = 14'd1264;
      5'd16:   w = 14'd62;
      5'd17:   w = 14'd3924;
      5'd18:   w = 14'd4146;
      5'd19:   w = 14'd5935;
      5'd20:   w = 14'd1807;
      5'd21:   w = 14'd641;
      5'd22:   w = 14'd1547;
      5'd23:   w = 14'd98;
      5'd24:   w = 14'd1294;
      5'd25:   w = 14'd48;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/vkr_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
module vkr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 832,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vkr_hist.sv =====
// Letter filter, key position counter and histogram read-modify-write pipe.
`include "vigenere_key_recovery_defines.svh"

module vkr_hist #(
  parameter int unsigned MAX_KEY    = vkr_pkg::MAX_KEY_DEF,
  parameter int unsigned COUNT_BITS = vkr_pkg::COUNT_BITS_DEF,
  localparam int unsigned DEPTH  = MAX_KEY * vkr_pkg::ALPHABET,
  localparam int unsigned ADDR_W = $clog2(DEPTH),
  localparam int unsigned KLEN_W = $clog2(MAX_KEY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            raw_byte_i,
  input  logic [KLEN_W-1:0]     klen_i,
  input  logic                  clr_i,
  output logic [ADDR_W-1:0]     raddr_o,
  input  logic [COUNT_BITS-1:0] rdata_i,
  output logic                  we_o,
  output logic [ADDR_W-1:0]     waddr_o,
  output logic [COUNT_BITS-1:0] wdata_o
);

  localparam int unsigned POS_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int unsigned CMP_W = KLEN_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  is_lower, is_upper, is_letter, upd;
  logic [4:0]            letter;
  logic [POS_W-1:0]      pos_q, pos_d, pos_use, pos_next;
  logic [CMP_W-1:0]      pos_inc;
  logic [ADDR_W-1:0]     addr;
  logic                  s2_vld_q, fwd_vld_q;
  logic [ADDR_W-1:0]     s2_addr_q, fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q, src, cnt_new;

  // letter decode, case folded
  always_comb begin
    is_lower  = (raw_byte_i >= vkr_pkg::CH_LC_A) && (raw_byte_i <= vkr_pkg::CH_LC_Z);
    is_upper  = (raw_byte_i >= vkr_pkg::CH_UC_A) && (raw_byte_i <= vkr_pkg::CH_UC_Z);
    is_letter = is_lower || is_upper;
    letter    = is_lower ? 5'(raw_byte_i - vkr_pkg::CH_LC_A)
                         : 5'(raw_byte_i - vkr_pkg::CH_UC_A);
    upd       = accept_i && is_letter;
  end

  // key position; wraps if the key length shrank under it
  always_comb begin
    pos_use  = (CMP_W'(pos_q) >= CMP_W'(klen_i)) ? '0 : pos_q;
    pos_inc  = CMP_W'(pos_use) + CMP_W'(1);
    pos_next = (pos_inc >= CMP_W'(klen_i)) ? '0 : POS_W'(pos_inc);
    addr     = ADDR_W'(pos_use) * ADDR_W'(vkr_pkg::ALPHABET) + ADDR_W'(letter);
    if (clr_i) begin
      pos_d = '0;
    end else if (upd) begin
      pos_d = pos_next;
    end else begin
      pos_d = pos_q;
    end
  end

  assign raddr_o = addr;

  // stage 2: saturating increment, forwarded from the previous cycle's write
  always_comb begin
    src     = (fwd_vld_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : rdata_i;
    cnt_new = (src == CNT_MAX) ? src : src + COUNT_BITS'(1);
  end

  assign we_o    = s2_vld_q;
  assign waddr_o = s2_addr_q;
  assign wdata_o = cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      s2_vld_q  <= upd;
      fwd_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q  <= addr;
    fwd_addr_q <= s2_addr_q;
    fwd_data_q <= cnt_new;
  end

  `VKR_ASSERT_NOW(a_wr_after_accept, we_o, $past(accept_i), "histogram write without request")

endmodule

// ===== sv/vkr_score.sv =====
// Scoring engine: loads one column, scores all 26 shifts, keeps the best.
`include "vigenere_key_recovery_defines.svh"

module vkr_score #(
  parameter int unsigned MAX_KEY    = vkr_pkg::MAX_KEY_DEF,
  parameter int unsigned COUNT_BITS = vkr_pkg::COUNT_BITS_DEF,
  localparam int unsigned DEPTH  = MAX_KEY * vkr_pkg::ALPHABET,
  localparam int unsigned ADDR_W = $clog2(DEPTH),
  localparam int unsigned POS_W  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vkr_pkg::eng_ctrl_t    ctrl_i,
  input  logic [POS_W-1:0]      col_i,
  output logic [ADDR_W-1:0]     raddr_o,
  input  logic [COUNT_BITS-1:0] rdata_i,
  output vkr_pkg::res_t         res_o
);

  localparam int unsigned PROD_W = vkr_pkg::WEIGHT_W + COUNT_BITS;
  localparam int unsigned SUM_W  = PROD_W + 5;
  localparam int unsigned STEP_W = vkr_pkg::STEP_W;
  localparam int unsigned SH_W   = vkr_pkg::SHIFT_W;
  localparam logic [STEP_W-1:0] LOAD_END  = STEP_W'(vkr_pkg::ALPHABET);
  localparam logic [STEP_W-1:0] ROT_STEP  = STEP_W'(vkr_pkg::ALPHABET);
  localparam logic [STEP_W-1:0] DIFF_STEP = STEP_W'(vkr_pkg::ALPHABET + 1);
  localparam logic [STEP_W-1:0] CMP_STEP  = STEP_W'(vkr_pkg::ALPHABET + 2);
  localparam logic [SH_W-1:0]   LAST_SH   = SH_W'(vkr_pkg::ALPHABET - 1);
  localparam logic [SUM_W-1:0]  TARGET_K  = SUM_W'(vkr_pkg::TARGET_SCORE);

  vkr_pkg::eng_state_e state_q, state_d;

  logic [STEP_W-1:0]     k_q, i_q;
  logic [SH_W-1:0]       g_q, best_g_q;
  logic                  rd_vld_q, prod_vld_q, issue;
  logic [COUNT_BITS-1:0] rot_q [vkr_pkg::ALPHABET];
  logic [COUNT_BITS-1:0] n_q;
  logic [COUNT_BITS:0]   n_sum;
  logic [SUM_W-1:0]      target_q, acc_q, diff_q, best_q;
  logic [PROD_W-1:0]     prod_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vkr_pkg::EN_IDLE:   if (ctrl_i.start) state_d = vkr_pkg::EN_LOAD;
      vkr_pkg::EN_LOAD:   if (k_q == LOAD_END) state_d = vkr_pkg::EN_TARGET;
      vkr_pkg::EN_TARGET: state_d = vkr_pkg::EN_SHIFT;
      vkr_pkg::EN_SHIFT:  if (i_q == CMP_STEP && g_q == LAST_SH) state_d = vkr_pkg::EN_DONE;
      vkr_pkg::EN_DONE: begin
        if (ctrl_i.take) begin
          state_d = ctrl_i.start ? vkr_pkg::EN_LOAD : vkr_pkg::EN_IDLE;
        end
      end
      default:            state_d = vkr_pkg::EN_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue       = (state_q == vkr_pkg::EN_LOAD) && (k_q != LOAD_END);
    raddr_o     = ADDR_W'(col_i) * ADDR_W'(vkr_pkg::ALPHABET) + ADDR_W'(k_q);
    res_o.valid = (state_q == vkr_pkg::EN_DONE);
    res_o.shift = best_g_q;
    n_sum       = {1'b0, n_q} + {1'b0, rdata_i};
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vkr_pkg::EN_IDLE;
      k_q        <= '0;
      i_q        <= '0;
      g_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= (state_q == vkr_pkg::EN_SHIFT) && (i_q < ROT_STEP);
      if (ctrl_i.start) begin
        k_q <= '0;
      end else if (issue) begin
        k_q <= k_q + STEP_W'(1);
      end
      if (state_q == vkr_pkg::EN_TARGET) begin
        i_q <= '0;
        g_q <= '0;
      end else if (state_q == vkr_pkg::EN_SHIFT) begin
        if (i_q == CMP_STEP) begin
          i_q <= '0;
          if (g_q != LAST_SH) g_q <= g_q + SH_W'(1);
        end else begin
          i_q <= i_q + STEP_W'(1);
        end
      end
    end
  end

  // count window: shifted in while loading, rotated once per step while scoring
  // except on the difference and compare steps. The column total is the
  // saturated sum of its counts, which equals the column's saturated letter count.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int j = 0; j < vkr_pkg::ALPHABET - 1; j++) begin
        rot_q[j] <= rot_q[j+1];
      end
      rot_q[vkr_pkg::ALPHABET-1] <= rdata_i;
    end else if (state_q == vkr_pkg::EN_SHIFT && i_q <= ROT_STEP) begin
      for (int j = 0; j < vkr_pkg::ALPHABET; j++) begin
        rot_q[j] <= rot_q[(j + 1) % vkr_pkg::ALPHABET];
      end
    end

    if (ctrl_i.start) begin
      n_q <= '0;
    end else if (rd_vld_q) begin
      n_q <= n_sum[COUNT_BITS] ? '1 : n_sum[COUNT_BITS-1:0];
    end

    if (state_q == vkr_pkg::EN_TARGET) begin
      target_q <= SUM_W'(n_q) * TARGET_K;
    end

    // multiply, then accumulate
    prod_q <= PROD_W'(vkr_pkg::eng_weight(i_q)) * PROD_W'(rot_q[0]);
    if (ctrl_i.start || (state_q == vkr_pkg::EN_SHIFT && i_q == DIFF_STEP)) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end

    if (state_q == vkr_pkg::EN_SHIFT && i_q == DIFF_STEP) begin
      diff_q <= (acc_q >= target_q) ? acc_q - target_q : target_q - acc_q;
    end

    // lowest shift wins a tie
    if (state_q == vkr_pkg::EN_SHIFT && i_q == CMP_STEP) begin
      if (g_q == '0 || diff_q < best_q) begin
        best_q   <= diff_q;
        best_g_q <= g_q;
      end
    end
  end

  `VKR_ASSERT_NOW(a_shift_range, res_o.valid, res_o.shift <= LAST_SH, "shift out of range")

endmodule

// ===== sv/vigenere_key_recovery.sv =====
// Top level: config register, message sequencer, histogram memory, output stage.
//
//  channel   dir  request fields             handshake
//  --------  ---  -------------------------  -------------------------
//  input     in   raw_byte_i, is_last_i      in_valid_i / in_stall_o
//  output    out  key_letter_o, last_letter_o out_valid_o / out_stall_i
//  config    in   key_length (paddr 0)       psel/penable/pwrite, pready=1
//
// Streaming: one byte per cycle; the histogram read-modify-write pipe
// forwards back-to-back hits on one counter.
// After the last byte: the drain state, then for each key position a load of
// 26 counts, the target step, 26 shifts scored on one multiplier and the
// hand-off, plus any output stall. Then a clearing pass through the whole
// histogram memory; the same pass runs after reset. Input stalls from the
// last byte until the pass ends. A stalled output holds the scoring engine
// in its done state.
`include "vigenere_key_recovery_defines.svh"

module vigenere_key_recovery #(
  parameter int unsigned MAX_KEY    = vkr_pkg::MAX_KEY_DEF,
  parameter int unsigned COUNT_BITS = vkr_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  raw_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  key_letter_o,
  output logic        last_letter_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH  = MAX_KEY * vkr_pkg::ALPHABET;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned POS_W  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int unsigned KLEN_W = $clog2(MAX_KEY + 1);
  localparam int unsigned CMP_W  = KLEN_W + 1;

  vkr_pkg::top_state_e state_q, state_d;
  vkr_pkg::eng_ctrl_t  eng_ctrl;
  vkr_pkg::res_t       eng_res;

  logic [5:0]            key_length_q;
  logic [6:0]            eff_len;
  logic [KLEN_W-1:0]     klen;
  logic [ADDR_W-1:0]     clr_q;
  logic                  clr_last;
  logic [POS_W-1:0]      col_q;
  logic                  col_last, out_free, in_acc;
  logic                  out_valid_q, last_letter_q;
  logic [6:0]            key_letter_q;

  logic                  hist_we, ram_we;
  logic [ADDR_W-1:0]     hist_raddr, hist_waddr, eng_raddr, ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] hist_wdata, ram_wdata, ram_rdata;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == vkr_pkg::REG_KEY_LENGTH) ? {26'b0, key_length_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= vkr_pkg::KEY_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == vkr_pkg::REG_KEY_LENGTH) begin
      key_length_q <= pwdata[5:0];
    end
  end

  // effective key length: zero counts as one, clipped to MAX_KEY
  always_comb begin
    if (key_length_q == 6'd0) begin
      eff_len = 7'd1;
    end else if ({1'b0, key_length_q} > 7'(MAX_KEY)) begin
      eff_len = 7'(MAX_KEY);
    end else begin
      eff_len = {1'b0, key_length_q};
    end
    klen = KLEN_W'(eff_len);
  end

  always_comb begin
    in_acc   = in_valid_i && !in_stall_o;
    clr_last = (clr_q == ADDR_W'(DEPTH - 1));
    col_last = (CMP_W'(col_q) + CMP_W'(1)) == CMP_W'(klen);
    out_free = !out_valid_q || !out_stall_i;
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vkr_pkg::ST_CLEAR: if (clr_last) state_d = vkr_pkg::ST_RUN;
      vkr_pkg::ST_RUN:   if (in_acc && is_last_i) state_d = vkr_pkg::ST_DRAIN;
      vkr_pkg::ST_DRAIN: state_d = vkr_pkg::ST_SCORE;
      vkr_pkg::ST_SCORE: if (eng_res.valid) state_d = vkr_pkg::ST_EMIT;
      vkr_pkg::ST_EMIT: begin
        if (out_free) state_d = col_last ? vkr_pkg::ST_CLEAR : vkr_pkg::ST_SCORE;
      end
      default:           state_d = vkr_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o     = (state_q != vkr_pkg::ST_RUN);
    eng_ctrl.take  = (state_q == vkr_pkg::ST_EMIT) && out_free;
    eng_ctrl.start = (state_q == vkr_pkg::ST_DRAIN) || (eng_ctrl.take && !col_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vkr_pkg::ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vkr_pkg::ST_CLEAR) begin
        clr_q <= clr_last ? '0 : clr_q + ADDR_W'(1);
      end
      if (state_q == vkr_pkg::ST_RUN) begin
        col_q <= '0;
      end else if (eng_ctrl.take && !col_last) begin
        col_q <= col_q + POS_W'(1);
      end
      if (eng_ctrl.take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (eng_ctrl.take) begin
      key_letter_q  <= vkr_pkg::KEY_BASE + 7'(eng_res.shift);
      last_letter_q <= col_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_letter_o  = key_letter_q;
  assign last_letter_o = last_letter_q;

  // memory port steering
  always_comb begin
    if (state_q == vkr_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = hist_we;
      ram_waddr = hist_waddr;
      ram_wdata = hist_wdata;
    end
    ram_raddr = (state_q == vkr_pkg::ST_SCORE) ? eng_raddr : hist_raddr;
  end

  vkr_hist #(
    .MAX_KEY    (MAX_KEY),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .raw_byte_i (raw_byte_i),
    .klen_i     (klen),
    .clr_i      (state_q == vkr_pkg::ST_CLEAR),
    .raddr_o    (hist_raddr),
    .rdata_i    (ram_rdata),
    .we_o       (hist_we),
    .waddr_o    (hist_waddr),
    .wdata_o    (hist_wdata)
  );

  vkr_score #(
    .MAX_KEY    (MAX_KEY),
    .COUNT_BITS (COUNT_BITS)
  ) u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (eng_ctrl),
    .col_i   (col_q),
    .raddr_o (eng_raddr),
    .rdata_i (ram_rdata),
    .res_o   (eng_res)
  );

  vkr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `VKR_ASSERT_NEXT(a_last_stalls, in_acc && is_last_i, in_stall_o, "request taken after last byte")
  `VKR_ASSERT_NOW(a_clear_excl, state_q == vkr_pkg::ST_CLEAR, !hist_we, "clear pass collides")
  `VKR_ASSERT_NOW(a_letter_range, out_valid_o, key_letter_o >= vkr_pkg::KEY_BASE && key_letter_o <= 7'(vkr_pkg::CH_LC_Z), "key letter out of range")

endmodule
